@@ hw/rtl/flhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flhc_pkg
// Shared types, codes and level search helpers for the five-level
// hysteresis classifier.
// ----------------------------------------------------------------------------
package flhc_pkg;

	localparam int NUM_LEVELS        = 5;
	localparam int LVL_W             = 3;
	localparam int CTRL_W            = 9;
	localparam int DEF_SAMPLE_WIDTH  = 12;
	localparam int DEF_COUNT_WIDTH   = 8;
	localparam int CFG_IDX_W         = 3;

	typedef logic [LVL_W-1:0] level_t;

	localparam level_t LEVEL_A = 3'd0;
	localparam level_t LEVEL_E = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONTROL         = 3'd0,
		REG_THRESHOLDS      = 3'd1,
		REG_UP_COUNTS       = 3'd2,
		REG_DOWN_COUNTS     = 3'd3,
		REG_EVENT_COUNTS    = 3'd4,
		REG_INTERVAL_COUNTS = 3'd5,
		REG_SAMPLE_COUNTS   = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_RESTART  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		MOVE_NONE = 2'd0,
		MOVE_UP   = 2'd1,
		MOVE_DOWN = 2'd2
	} moved_t;

	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DOWN = 2'd2
	} act_t;

	typedef struct packed {
		logic [NUM_LEVELS-1:0] present_mask;
		logic [2:0]            start_level;
		logic                  sampling_mode;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = 9'h1F0;

	// level A is always present
	function automatic logic [NUM_LEVELS-1:0] present_lvls(input ctrl_t c);
		present_lvls = {c.present_mask[NUM_LEVELS-1:1], 1'b1};
	endfunction

	// nearest present level above l, or l itself
	function automatic level_t higher_lvl(input logic [NUM_LEVELS-1:0] pres, input level_t l);
		level_t res;
		res = l;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (i > int'(l) && pres[i]) begin
				res = level_t'(i);
			end
		end
		return res;
	endfunction

	// nearest present level below l, or A
	function automatic level_t lower_lvl(input logic [NUM_LEVELS-1:0] pres, input level_t l);
		level_t res;
		res = LEVEL_A;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (i < int'(l) && pres[i]) begin
				res = level_t'(i);
			end
		end
		return res;
	endfunction

	function automatic level_t start_lvl(input ctrl_t c);
		logic [NUM_LEVELS-1:0] pres;
		level_t                s;
		pres = present_lvls(c);
		s = (c.start_level > LEVEL_E) ? LEVEL_E : c.start_level;
		return pres[s] ? s : lower_lvl(pres, s);
	endfunction

endpackage

@@ hw/rtl/flhc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flhc_if
// Request channels of the classifier: sample requests, results and
// register writes.
// ----------------------------------------------------------------------------
interface flhc_item_if #(
	parameter int SAMPLE_WIDTH = flhc_pkg::DEF_SAMPLE_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface flhc_result_if;
	logic                       valid;
	logic                       ready;
	logic [flhc_pkg::LVL_W-1:0] level;
	logic [1:0]                 moved;

	modport source (output valid, output level, output moved, input ready);
	modport sink   (input valid, input level, input moved, output ready);
endinterface

interface flhc_cfg_if #(
	parameter int DATA_WIDTH = 5 * flhc_pkg::DEF_SAMPLE_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic [flhc_pkg::CFG_IDX_W-1:0] index;
	logic [DATA_WIDTH-1:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/flhc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flhc_cfg_regs
// Configuration register file: control, thresholds and the five count
// tables. Writes always accepted; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module flhc_cfg_regs #(
	parameter int SAMPLE_WIDTH = flhc_pkg::DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = flhc_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	flhc_cfg_if.sink                                    cfg,
	output flhc_pkg::ctrl_t                             ctrl,
	output logic [flhc_pkg::NUM_LEVELS*SAMPLE_WIDTH-1:0] thresholds,
	output logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  up_counts,
	output logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  down_counts,
	output logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  event_counts,
	output logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  interval_counts,
	output logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  sample_counts
);

	localparam int TW = flhc_pkg::NUM_LEVELS * SAMPLE_WIDTH;
	localparam int CTW = flhc_pkg::NUM_LEVELS * COUNT_WIDTH;
	localparam logic [CTW-1:0] COUNTS_RESET = {flhc_pkg::NUM_LEVELS{COUNT_WIDTH'(1)}};

	flhc_pkg::ctrl_t   ctrl_q;
	logic [TW-1:0]     thr_q;
	logic [CTW-1:0]    up_q;
	logic [CTW-1:0]    down_q;
	logic [CTW-1:0]    event_q;
	logic [CTW-1:0]    interval_q;
	logic [CTW-1:0]    smp_q;
	logic              wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= flhc_pkg::CTRL_RESET;
			thr_q      <= '0;
			up_q       <= COUNTS_RESET;
			down_q     <= COUNTS_RESET;
			event_q    <= COUNTS_RESET;
			interval_q <= COUNTS_RESET;
			smp_q      <= COUNTS_RESET;
		end else if (wr) begin
			unique case (flhc_pkg::cfg_reg_t'(cfg.index))
				flhc_pkg::REG_CONTROL:         ctrl_q     <= cfg.data[flhc_pkg::CTRL_W-1:0];
				flhc_pkg::REG_THRESHOLDS:      thr_q      <= cfg.data[TW-1:0];
				flhc_pkg::REG_UP_COUNTS:       up_q       <= cfg.data[CTW-1:0];
				flhc_pkg::REG_DOWN_COUNTS:     down_q     <= cfg.data[CTW-1:0];
				flhc_pkg::REG_EVENT_COUNTS:    event_q    <= cfg.data[CTW-1:0];
				flhc_pkg::REG_INTERVAL_COUNTS: interval_q <= cfg.data[CTW-1:0];
				flhc_pkg::REG_SAMPLE_COUNTS:   smp_q      <= cfg.data[CTW-1:0];
				default: ;
			endcase
		end
	end

	assign ctrl            = ctrl_q;
	assign thresholds      = thr_q;
	assign up_counts       = up_q;
	assign down_counts     = down_q;
	assign event_counts    = event_q;
	assign interval_counts = interval_q;
	assign sample_counts   = smp_q;

endmodule

@@ hw/rtl/flhc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flhc_core
// Input register, level/counter state with its one-pass update, and the
// result register.
// ----------------------------------------------------------------------------
module flhc_core #(
	parameter int SAMPLE_WIDTH = flhc_pkg::DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = flhc_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	flhc_item_if.sink                                    samples,
	flhc_result_if.source                                results,
	input  flhc_pkg::ctrl_t                              ctrl,
	input  logic [flhc_pkg::NUM_LEVELS*SAMPLE_WIDTH-1:0] thresholds,
	input  logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  up_counts,
	input  logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  down_counts,
	input  logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  event_counts,
	input  logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  interval_counts,
	input  logic [flhc_pkg::NUM_LEVELS*COUNT_WIDTH-1:0]  sample_counts
);

	localparam int NL = flhc_pkg::NUM_LEVELS;
	localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

	logic signed [SAMPLE_WIDTH-1:0] thr_f   [NL];
	logic [COUNT_WIDTH-1:0]         up_f    [NL];
	logic [COUNT_WIDTH-1:0]         down_f  [NL];
	logic [COUNT_WIDTH-1:0]         event_f [NL];
	logic [COUNT_WIDTH-1:0]         intv_f  [NL];
	logic [COUNT_WIDTH-1:0]         smp_f   [NL];

	for (genvar g = 0; g < NL; g++) begin : g_fields
		assign thr_f[g]   = thresholds[g*SAMPLE_WIDTH +: SAMPLE_WIDTH];
		assign up_f[g]    = up_counts[g*COUNT_WIDTH +: COUNT_WIDTH];
		assign down_f[g]  = down_counts[g*COUNT_WIDTH +: COUNT_WIDTH];
		assign event_f[g] = event_counts[g*COUNT_WIDTH +: COUNT_WIDTH];
		assign intv_f[g]  = interval_counts[g*COUNT_WIDTH +: COUNT_WIDTH];
		assign smp_f[g]   = sample_counts[g*COUNT_WIDTH +: COUNT_WIDTH];
	end

	// input stage
	logic                           valid_s1;
	logic                           op_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           out_free;
	logic                           advance;

	// result stage
	logic                   out_valid_q;
	flhc_pkg::level_t       out_level_q;
	flhc_pkg::moved_t       out_moved_q;

	// classifier state
	flhc_pkg::level_t       lvl_q;
	logic [COUNT_WIDTH-1:0] up_q;
	logic [COUNT_WIDTH-1:0] down_q;
	logic [COUNT_WIDTH-1:0] intv_q;
	logic [COUNT_WIDTH-1:0] smp_q;
	logic [COUNT_WIDTH-1:0] evt_q;
	logic                   flag_q;

	flhc_pkg::level_t       lvl_d;
	logic [COUNT_WIDTH-1:0] up_d;
	logic [COUNT_WIDTH-1:0] down_d;
	logic [COUNT_WIDTH-1:0] intv_d;
	logic [COUNT_WIDTH-1:0] smp_d;
	logic [COUNT_WIDTH-1:0] evt_d;
	logic                   flag_d;
	flhc_pkg::moved_t       moved_d;

	logic [NL-1:0]          pres;
	flhc_pkg::level_t       hi;
	flhc_pkg::level_t       lo;
	flhc_pkg::level_t       st;
	flhc_pkg::act_t         act;
	logic [COUNT_WIDTH-1:0] up_dec;
	logic [COUNT_WIDTH-1:0] down_dec;
	logic [COUNT_WIDTH-1:0] intv_dec;
	logic [COUNT_WIDTH-1:0] smp_dec;
	logic [COUNT_WIDTH-1:0] evt_dec;

	assign out_free      = !out_valid_q || results.ready;
	assign advance       = valid_s1 && out_free;
	assign samples.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			op_s1     <= samples.opcode;
			sample_s1 <= samples.sample;
		end
	end

	assign pres     = flhc_pkg::present_lvls(ctrl);
	assign hi       = flhc_pkg::higher_lvl(pres, lvl_q);
	assign lo       = flhc_pkg::lower_lvl(pres, lvl_q);
	assign st       = flhc_pkg::start_lvl(ctrl);
	assign up_dec   = up_q - ONE;
	assign down_dec = down_q - ONE;
	assign intv_dec = intv_q - ONE;
	assign smp_dec  = smp_q - ONE;
	assign evt_dec  = evt_q - ONE;

	always_comb begin
		act = flhc_pkg::ACT_HOLD;
		if (lvl_q == flhc_pkg::LEVEL_E) begin
			if (sample_s1 < thr_f[flhc_pkg::LEVEL_E]) act = flhc_pkg::ACT_DOWN;
		end else if (lvl_q == flhc_pkg::LEVEL_A) begin
			if (sample_s1 > thr_f[flhc_pkg::LEVEL_A]) act = flhc_pkg::ACT_UP;
		end else if (sample_s1 > thr_f[lvl_q]) begin
			act = flhc_pkg::ACT_UP;
		end else if (sample_s1 <= thr_f[lo]) begin
			act = flhc_pkg::ACT_DOWN;
		end
	end

	always_comb begin
		lvl_d  = lvl_q;
		up_d   = up_q;
		down_d = down_q;
		intv_d = intv_q;
		smp_d  = smp_q;
		evt_d  = evt_q;
		flag_d = flag_q;
		if (flhc_pkg::opcode_t'(op_s1) == flhc_pkg::OP_RESTART) begin
			lvl_d  = st;
			up_d   = up_f[st];
			down_d = down_f[st];
			intv_d = intv_f[st];
			smp_d  = smp_f[st];
			evt_d  = event_f[st];
			flag_d = 1'b1;
		end else if (!ctrl.sampling_mode) begin
			case (act)
				flhc_pkg::ACT_UP: begin
					if (up_dec == '0) begin
						lvl_d  = hi;
						up_d   = up_f[hi];
						down_d = down_f[hi];
					end else begin
						up_d   = up_dec;
						down_d = down_f[lvl_q];
					end
				end
				flhc_pkg::ACT_DOWN: begin
					if (down_dec == '0) begin
						lvl_d  = lo;
						up_d   = up_f[lo];
						down_d = down_f[lo];
					end else begin
						up_d   = up_f[lvl_q];
						down_d = down_dec;
					end
				end
				default: begin
					up_d   = up_f[lvl_q];
					down_d = down_f[lvl_q];
				end
			endcase
		end else begin
			case (act)
				flhc_pkg::ACT_UP: begin
					down_d = down_f[lvl_q];
					if (!flag_q) begin
						if (intv_dec == '0) begin
							flag_d = 1'b1;
							intv_d = intv_f[lvl_q];
						end else begin
							intv_d = intv_dec;
						end
					end else if (smp_dec != '0) begin
						smp_d = smp_dec;
					end else if (evt_dec == '0) begin
						lvl_d  = hi;
						down_d = down_f[hi];
						intv_d = intv_f[hi];
						smp_d  = smp_f[hi];
						evt_d  = event_f[hi];
					end else begin
						evt_d  = evt_dec;
						intv_d = intv_f[lvl_q];
						smp_d  = smp_f[lvl_q];
						flag_d = 1'b0;
					end
				end
				flhc_pkg::ACT_DOWN: begin
					if (down_dec == '0) begin
						lvl_d  = lo;
						down_d = down_f[lo];
						intv_d = intv_f[lo];
						smp_d  = smp_f[lo];
						evt_d  = event_f[lo];
						flag_d = 1'b1;
					end else begin
						down_d = down_dec;
						if (flag_q) begin
							evt_d = event_f[lvl_q];
							smp_d = smp_f[lvl_q];
						end else if (intv_dec == '0) begin
							flag_d = 1'b1;
							intv_d = intv_f[lvl_q];
						end else begin
							intv_d = intv_dec;
						end
					end
				end
				default: begin
					down_d = down_f[lvl_q];
					if (flag_q) begin
						intv_d = intv_f[lvl_q];
						evt_d  = event_f[lvl_q];
						smp_d  = smp_f[lvl_q];
					end else if (intv_dec == '0) begin
						flag_d = 1'b1;
						intv_d = intv_f[lvl_q];
					end else begin
						intv_d = intv_dec;
					end
				end
			endcase
		end
	end

	always_comb begin
		moved_d = flhc_pkg::MOVE_NONE;
		if (flhc_pkg::opcode_t'(op_s1) == flhc_pkg::OP_CLASSIFY) begin
			if (lvl_d > lvl_q) begin
				moved_d = flhc_pkg::MOVE_UP;
			end else if (lvl_d < lvl_q) begin
				moved_d = flhc_pkg::MOVE_DOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= flhc_pkg::LEVEL_A;
			up_q   <= ONE;
			down_q <= ONE;
			intv_q <= ONE;
			smp_q  <= ONE;
			evt_q  <= ONE;
			flag_q <= 1'b1;
		end else if (advance) begin
			lvl_q  <= lvl_d;
			up_q   <= up_d;
			down_q <= down_d;
			intv_q <= intv_d;
			smp_q  <= smp_d;
			evt_q  <= evt_d;
			flag_q <= flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q <= lvl_d;
			out_moved_q <= moved_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.level = out_level_q;
	assign results.moved = out_moved_q;

endmodule

@@ hw/rtl/five_level_hysteresis_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_level_hysteresis_classifier_unit
// Five-level hysteresis classifier with persistence and sampling counters.
// ----------------------------------------------------------------------------
// Usage:
//   samples : request stream, opcode (classify / restart) and signed sample.
//   results : one result per request, level after the step and move code.
//   cfg     : register writes (index, data), always ready; write only while
//             no request is in flight.
// Path: an accepted request is held in the input register, then its result
//   is registered in the result register, when results is not stalled.
// Throughput: one request per cycle while results is not stalled. The level
//   and counter update is a single pass of compare and decrement logic
//   between the input register and the state/result registers.
// Stall: with results stalled the result register holds; an empty input
//   register still takes one more request, then samples.ready drops.
// Reset: registers return to their reset values, state starts at level A
//   with all counters at one; both streams come up empty.
// ----------------------------------------------------------------------------
module five_level_hysteresis_classifier_unit #(
	parameter int SAMPLE_WIDTH = flhc_pkg::DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = flhc_pkg::DEF_COUNT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	flhc_item_if.sink     samples,
	flhc_result_if.source results,
	flhc_cfg_if.sink      cfg
);

	localparam int TW  = flhc_pkg::NUM_LEVELS * SAMPLE_WIDTH;
	localparam int CTW = flhc_pkg::NUM_LEVELS * COUNT_WIDTH;

	flhc_pkg::ctrl_t ctrl;
	logic [TW-1:0]   thresholds;
	logic [CTW-1:0]  up_counts;
	logic [CTW-1:0]  down_counts;
	logic [CTW-1:0]  event_counts;
	logic [CTW-1:0]  interval_counts;
	logic [CTW-1:0]  sample_counts;

	flhc_cfg_regs #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_cfg_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.ctrl            (ctrl),
		.thresholds      (thresholds),
		.up_counts       (up_counts),
		.down_counts     (down_counts),
		.event_counts    (event_counts),
		.interval_counts (interval_counts),
		.sample_counts   (sample_counts)
	);

	flhc_core #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.samples         (samples),
		.results         (results),
		.ctrl            (ctrl),
		.thresholds      (thresholds),
		.up_counts       (up_counts),
		.down_counts     (down_counts),
		.event_counts    (event_counts),
		.interval_counts (interval_counts),
		.sample_counts   (sample_counts)
	);

endmodule

@@ hw/rtl/flhc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flhc_chk
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module flhc_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [flhc_pkg::LVL_W-1:0] out_level,
	input logic [1:0]                 out_moved
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_moved))
		else $error("result changed while stalled");

	// every accepted request has a result pending once it has passed the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result after accepted request");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_level <= flhc_pkg::LEVEL_E && out_moved != 2'd3)
		else $error("result level or move code out of range");

	// an up step cannot land on A, a down step cannot land on E
	a_move_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_moved == flhc_pkg::MOVE_UP && out_level == flhc_pkg::LEVEL_A)
			&& !(out_moved == flhc_pkg::MOVE_DOWN && out_level == flhc_pkg::LEVEL_E))
		else $error("move direction inconsistent with level");

endmodule

bind five_level_hysteresis_classifier_unit flhc_chk u_flhc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_level (results.level),
	.out_moved (results.moved)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the five-level hysteresis classifier. A local
// predictor tracks level, persistence and sampling counters per request.
// Directed tests cover the level ends, restart, start-level resolution,
// absent levels and sampling mode. Random phases then reconfigure the block
// and drive trend-following samples. Both streams stall at random, and one
// long result stall backs up the input stream.
// ----------------------------------------------------------------------------
module testbench;
	import flhc_pkg::*;

	localparam int SAMPLE_BITS  = DEF_SAMPLE_WIDTH;
	localparam int COUNT_BITS   = DEF_COUNT_WIDTH;
	localparam int THR_BITS     = NUM_LEVELS * SAMPLE_BITS;
	localparam int CNT_BITS     = NUM_LEVELS * COUNT_BITS;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		level_t level;
		moved_t moved;
	} level_result_t;

	logic clk;
	logic arst_n;

	flhc_item_if #(.SAMPLE_WIDTH(SAMPLE_BITS)) item_bus();
	flhc_result_if result_bus();
	flhc_cfg_if #(.DATA_WIDTH(THR_BITS)) cfg_bus();

	five_level_hysteresis_classifier_unit #(
		.SAMPLE_WIDTH(SAMPLE_BITS),
		.COUNT_WIDTH(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(item_bus),
		.results(result_bus),
		.cfg(cfg_bus)
	);

	// register copies
	logic [CTRL_W-1:0]   ctrl_reg;
	logic [THR_BITS-1:0] thr_reg;
	logic [CNT_BITS-1:0] up_reg, down_reg, event_reg, interval_reg, sample_reg;

	// classifier state
	int                  cur_level;
	logic [COUNT_BITS-1:0] up_cnt, dn_cnt, iv_cnt, sm_cnt, ev_cnt;
	bit                  proc_flag;

	level_result_t pending_levels[$];
	int            mismatch_count = 0;
	bit            gaps_on = 1'b1;
	int            hold_results = 0;
	bit            trend_up = 1'b1;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] thr_of(input int l);
		return thr_reg[SAMPLE_BITS*l +: SAMPLE_BITS];
	endfunction

	function automatic logic [COUNT_BITS-1:0] cnt_of(input logic [CNT_BITS-1:0] r, input int l);
		return r[COUNT_BITS*l +: COUNT_BITS];
	endfunction

	function automatic bit lvl_present(input int l);
		return l == 0 || ctrl_reg[4+l];
	endfunction

	function automatic int level_above(input int l);
		for (int i = l + 1; i < NUM_LEVELS; i++)
			if (lvl_present(i))
				return i;
		return l;
	endfunction

	function automatic int level_below(input int l);
		for (int i = l; i > 0; i--)
			if (lvl_present(i - 1))
				return i - 1;
		return 0;
	endfunction

	function automatic int clamp_sample(input int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return v;
	endfunction

	task automatic load_level_counts(input int l);
		dn_cnt = cnt_of(down_reg, l);
		iv_cnt = cnt_of(interval_reg, l);
		sm_cnt = cnt_of(sample_reg, l);
		ev_cnt = cnt_of(event_reg, l);
	endtask

	task automatic restart_state();
		int s;
		s = ctrl_reg[3:1];
		if (s > 4)
			s = 4;
		while (s > 0 && !lvl_present(s))
			s--;
		cur_level = s;
		up_cnt = cnt_of(up_reg, s);
		load_level_counts(s);
		proc_flag = 1'b1;
	endtask

	task automatic interval_tick(input int l);
		iv_cnt = iv_cnt - 1'b1;
		if (iv_cnt == 0) begin
			proc_flag = 1'b1;
			iv_cnt = cnt_of(interval_reg, l);
		end
	endtask

	task automatic predict_level_step(input opcode_t op, input logic signed [SAMPLE_BITS-1:0] smp,
			output level_t lv, output moved_t mv);
		int   lvl;
		int   nl;
		act_t act;
		if (op == OP_RESTART) begin
			restart_state();
			lv = level_t'(cur_level);
			mv = MOVE_NONE;
			return;
		end
		lvl = cur_level;
		act = ACT_HOLD;
		if (lvl == 4) begin
			if (smp < thr_of(4))
				act = ACT_DOWN;
		end else if (lvl == 0) begin
			if (smp > thr_of(0))
				act = ACT_UP;
		end else if (smp > thr_of(lvl)) begin
			act = ACT_UP;
		end else if (smp <= thr_of(level_below(lvl))) begin
			act = ACT_DOWN;
		end

		if (!ctrl_reg[0]) begin
			case (act)
				ACT_UP: begin
					dn_cnt = cnt_of(down_reg, lvl);
					up_cnt = up_cnt - 1'b1;
					if (up_cnt == 0) begin
						nl = level_above(lvl);
						cur_level = nl;
						up_cnt = cnt_of(up_reg, nl);
						dn_cnt = cnt_of(down_reg, nl);
					end
				end
				ACT_DOWN: begin
					up_cnt = cnt_of(up_reg, lvl);
					dn_cnt = dn_cnt - 1'b1;
					if (dn_cnt == 0) begin
						nl = level_below(lvl);
						cur_level = nl;
						up_cnt = cnt_of(up_reg, nl);
						dn_cnt = cnt_of(down_reg, nl);
					end
				end
				default: begin
					up_cnt = cnt_of(up_reg, lvl);
					dn_cnt = cnt_of(down_reg, lvl);
				end
			endcase
		end else begin
			case (act)
				ACT_UP: begin
					dn_cnt = cnt_of(down_reg, lvl);
					if (!proc_flag) begin
						interval_tick(lvl);
					end else begin
						sm_cnt = sm_cnt - 1'b1;
						if (sm_cnt == 0) begin
							ev_cnt = ev_cnt - 1'b1;
							if (ev_cnt == 0) begin
								nl = level_above(lvl);
								cur_level = nl;
								load_level_counts(nl);
							end else begin
								iv_cnt = cnt_of(interval_reg, lvl);
								sm_cnt = cnt_of(sample_reg, lvl);
								proc_flag = 1'b0;
							end
						end
					end
				end
				ACT_DOWN: begin
					dn_cnt = dn_cnt - 1'b1;
					if (dn_cnt == 0) begin
						nl = level_below(lvl);
						cur_level = nl;
						load_level_counts(nl);
						proc_flag = 1'b1;
					end else if (proc_flag) begin
						ev_cnt = cnt_of(event_reg, lvl);
						sm_cnt = cnt_of(sample_reg, lvl);
					end else begin
						interval_tick(lvl);
					end
				end
				default: begin
					if (proc_flag) begin
						iv_cnt = cnt_of(interval_reg, lvl);
						ev_cnt = cnt_of(event_reg, lvl);
						sm_cnt = cnt_of(sample_reg, lvl);
					end else begin
						interval_tick(lvl);
					end
					dn_cnt = cnt_of(down_reg, lvl);
				end
			endcase
		end

		lv = level_t'(cur_level);
		if (cur_level > lvl)
			mv = MOVE_UP;
		else if (cur_level < lvl)
			mv = MOVE_DOWN;
		else
			mv = MOVE_NONE;
	endtask

	// ---- stimulus helpers

	task automatic send_item(input opcode_t op, input int smp);
		int     gap;
		level_t lv;
		moved_t mv;
		gap = 0;
		if (gaps_on && $urandom_range(99) < 12)
			gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid  <= 1'b1;
		item_bus.opcode <= op;
		item_bus.sample <= SAMPLE_BITS'(smp);
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		predict_level_step(op, SAMPLE_BITS'(smp), lv, mv);
		pending_levels.push_back('{level: lv, moved: mv});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_BITS-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_CONTROL:         ctrl_reg     = data[CTRL_W-1:0];
			REG_THRESHOLDS:      thr_reg      = data;
			REG_UP_COUNTS:       up_reg       = data[CNT_BITS-1:0];
			REG_DOWN_COUNTS:     down_reg     = data[CNT_BITS-1:0];
			REG_EVENT_COUNTS:    event_reg    = data[CNT_BITS-1:0];
			REG_INTERVAL_COUNTS: interval_reg = data[CNT_BITS-1:0];
			REG_SAMPLE_COUNTS:   sample_reg   = data[CNT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [THR_BITS-1:0] pack_thresholds(input int a, input int b, input int c,
			input int d, input int e);
		return {SAMPLE_BITS'(e), SAMPLE_BITS'(d), SAMPLE_BITS'(c), SAMPLE_BITS'(b), SAMPLE_BITS'(a)};
	endfunction

	function automatic logic [THR_BITS-1:0] rand_counts(input int lo, input int hi);
		logic [THR_BITS-1:0] r;
		r = THR_BITS'({$urandom, $urandom});
		for (int i = 0; i < NUM_LEVELS; i++)
			r[COUNT_BITS*i +: COUNT_BITS] = COUNT_BITS'($urandom_range(lo, hi));
		return r;
	endfunction

	function automatic logic [THR_BITS-1:0] fill_counts(input logic [COUNT_BITS-1:0] c);
		return {{(THR_BITS-CNT_BITS){1'b0}}, {NUM_LEVELS{c}}};
	endfunction

	function automatic logic [THR_BITS-1:0] sorted_thresholds();
		logic [THR_BITS-1:0] r;
		int                  t;
		t = $urandom_range(0, 800) - 1600;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			r[SAMPLE_BITS*i +: SAMPLE_BITS] = SAMPLE_BITS'(t);
			t = clamp_sample(t + $urandom_range(50, 700));
		end
		return r;
	endfunction

	// follows a rising or falling trend around the current level's bounds
	function automatic int pick_sample();
		int r;
		int v;
		r = $urandom_range(99);
		if ($urandom_range(99) < 8)
			trend_up = !trend_up;
		if (r < 70) begin
			if (trend_up)
				v = int'(thr_of(cur_level)) + $urandom_range(1, 60);
			else if (cur_level == 4)
				v = int'(thr_of(4)) - $urandom_range(1, 60);
			else
				v = int'(thr_of(level_below(cur_level))) - $urandom_range(0, 60);
		end else if (r < 82) begin
			v = int'(thr_of($urandom_range(0, 4))) + $urandom_range(0, 4) - 2;
		end else if (r < 94) begin
			v = int'($urandom_range(0, 4095)) - 2048;
		end else begin
			v = r[0] ? 2047 : -2048;
		end
		return clamp_sample(v);
	endfunction

	// ---- result side

	always @(negedge clk) begin
		if (hold_results > 0) begin
			hold_results--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= !(gaps_on && $urandom_range(99) < 12);
		end
	end

	level_result_t exp_r;

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_levels.size() == 0) begin
				$error("result with no request pending: level %0d moved %0d",
					result_bus.level, result_bus.moved);
				mismatch_count++;
			end else begin
				exp_r = pending_levels.pop_front();
				if (result_bus.level !== exp_r.level) begin
					$error("level: expected %0d, got %0d", exp_r.level, result_bus.level);
					mismatch_count++;
				end
				if (result_bus.moved !== exp_r.moved) begin
					$error("moved: expected %0d, got %0d", exp_r.moved, result_bus.moved);
					mismatch_count++;
				end
			end
		end
	end

	// ---- tests

	task automatic test_reset_defaults();
		send_item(OP_CLASSIFY, 0);
		send_item(OP_CLASSIFY, 2047);
		send_item(OP_CLASSIFY, -2048);
		repeat (4) send_item(OP_CLASSIFY, 1);
		send_item(OP_CLASSIFY, 2047);
		send_item(OP_CLASSIFY, 0);
		send_item(OP_CLASSIFY, -1);
		send_item(OP_RESTART, 2047);
		settle();
	endtask

	task automatic test_start_and_mask();
		ctrl_t c;
		write_reg(REG_THRESHOLDS, pack_thresholds(-2048, -100, 0, 100, 2047));
		c.present_mask  = 5'b00101;
		c.start_level   = 3'd7;
		c.sampling_mode = 1'b0;
		write_reg(REG_CONTROL, THR_BITS'(c));
		send_item(OP_RESTART, -2048);
		send_item(OP_CLASSIFY, 2047);
		send_item(OP_CLASSIFY, -2048);
		send_item(OP_CLASSIFY, -2048);
		send_item(OP_RESTART, 0);
		settle();
		c.present_mask = 5'b01011;
		write_reg(REG_CONTROL, THR_BITS'(c));
		write_reg(REG_UNUSED, THR_BITS'({$urandom, $urandom}));
		send_item(OP_CLASSIFY, 50);
		send_item(OP_CLASSIFY, -200);
		send_item(OP_CLASSIFY, -100);
		settle();
	endtask

	task automatic test_sampling_mode();
		ctrl_t c;
		c.present_mask  = 5'b11111;
		c.start_level   = 3'd0;
		c.sampling_mode = 1'b1;
		write_reg(REG_CONTROL, THR_BITS'(c));
		write_reg(REG_EVENT_COUNTS, fill_counts(8'd2));
		write_reg(REG_INTERVAL_COUNTS, fill_counts(8'd2));
		write_reg(REG_SAMPLE_COUNTS, fill_counts(8'd2));
		write_reg(REG_DOWN_COUNTS, fill_counts(8'd2));
		send_item(OP_RESTART, 0);
		repeat (7) send_item(OP_CLASSIFY, 2047);
		repeat (3) send_item(OP_CLASSIFY, -2048);
		settle();
	endtask

	// a zero count only fires after the counter wraps all the way round
	task automatic test_count_wrap();
		write_reg(REG_CONTROL, THR_BITS'(CTRL_RESET));
		write_reg(REG_THRESHOLDS, '0);
		write_reg(REG_UP_COUNTS, fill_counts(8'd1) & ~THR_BITS'(8'hFF));
		write_reg(REG_DOWN_COUNTS, fill_counts(8'd1));
		send_item(OP_RESTART, 0);
		repeat (258) send_item(OP_CLASSIFY, $urandom_range(1, 2047));
		settle();
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		write_reg(REG_UP_COUNTS, rand_counts(1, 2));
		write_reg(REG_DOWN_COUNTS, rand_counts(1, 2));
		write_reg(REG_THRESHOLDS, sorted_thresholds());
		repeat (60) send_item(OP_CLASSIFY, pick_sample());
		settle();
		gaps_on = 1'b1;
	endtask

	task automatic test_result_backpressure();
		gaps_on = 1'b0;
		hold_results = 50;
		repeat (12) send_item(OP_CLASSIFY, pick_sample());
		settle();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0) begin
				write_reg(REG_CONTROL, {{(THR_BITS-CTRL_W){1'b1}}, {CTRL_W{1'b1}}});
				write_reg(REG_THRESHOLDS, pack_thresholds(2047, 2047, 2047, 2047, 2047));
				write_reg(REG_UP_COUNTS, fill_counts(8'd1));
				write_reg(REG_DOWN_COUNTS, fill_counts(8'd1));
				write_reg(REG_EVENT_COUNTS, fill_counts(8'd1));
				write_reg(REG_INTERVAL_COUNTS, fill_counts(8'd1));
				write_reg(REG_SAMPLE_COUNTS, fill_counts(8'd1));
			end else if (ph == 1) begin
				write_reg(REG_CONTROL, '0);
				write_reg(REG_THRESHOLDS, pack_thresholds(-2048, -2048, -2048, -2048, -2048));
				write_reg(REG_UP_COUNTS, fill_counts(8'hFF));
				write_reg(REG_DOWN_COUNTS, fill_counts(8'hFF));
				write_reg(REG_EVENT_COUNTS, fill_counts(8'hFF));
				write_reg(REG_INTERVAL_COUNTS, fill_counts(8'hFF));
				write_reg(REG_SAMPLE_COUNTS, fill_counts(8'hFF));
			end else begin
				write_reg(REG_CONTROL, THR_BITS'({$urandom, $urandom}));
				write_reg(REG_THRESHOLDS, ($urandom_range(3) == 0)
					? THR_BITS'({$urandom, $urandom}) : sorted_thresholds());
				write_reg(REG_UP_COUNTS, rand_counts(1, 3));
				write_reg(REG_DOWN_COUNTS, rand_counts(1, 3));
				write_reg(REG_EVENT_COUNTS, rand_counts(1, 3));
				write_reg(REG_INTERVAL_COUNTS, rand_counts(1, 3));
				write_reg(REG_SAMPLE_COUNTS, rand_counts(1, 3));
			end
			if (ph < 2 || $urandom_range(1))
				send_item(OP_RESTART, int'($urandom_range(0, 4095)) - 2048);
			repeat (55) begin
				if ($urandom_range(99) < 3)
					send_item(OP_RESTART, int'($urandom_range(0, 4095)) - 2048);
				else
					send_item(OP_CLASSIFY, pick_sample());
			end
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.opcode  = OP_CLASSIFY;
		item_bus.sample  = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = REG_CONTROL;
		cfg_bus.data     = '0;
		ctrl_reg     = CTRL_RESET;
		thr_reg      = '0;
		up_reg       = {NUM_LEVELS{8'h01}};
		down_reg     = up_reg;
		event_reg    = up_reg;
		interval_reg = up_reg;
		sample_reg   = up_reg;
		restart_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_start_and_mask();
		test_sampling_mode();
		test_count_wrap();
		test_back_to_back();
		test_result_backpressure();
		test_random_configs();

		settle();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
